// ----- rtl/etr_pkg.sv -----
// ----------------------------------------------------------------------------
// Elapsed time recorder package
// Shared widths, codes, payload structs and control structs of the recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package etr_pkg;

  localparam int unsigned SLOT_COUNT_DEF   = 16;
  localparam int unsigned WINDOW_CALLS_DEF = 128;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned DELTA_W    = 32;
  localparam int unsigned US_W       = 31;
  localparam int unsigned SLOT_NUM_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = 32;

  // Serial divider: full 64-bit dividend or a 32-bit dividend
  localparam int unsigned DIV_STEPS_FULL = STAMP_W;
  localparam int unsigned DIV_STEPS_HALF = DELTA_W;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS_FULL) + 1;

  // Microsecond scale is Q8.24
  localparam int unsigned US_FRAC_W = 24;
  localparam int unsigned PROD_W    = 2 * DELTA_W;

  localparam logic [CFG_W-1:0] CLOCKS_PER_MS_RST = 32'd1;
  localparam logic [CFG_W-1:0] US_SCALE_RST      = 32'h0100_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_SLOT_START   = 3'd0,
    KIND_SLOT_STOP    = 3'd1,
    KIND_SLOT_STOP_MS = 3'd2,
    KIND_US_START     = 3'd3,
    KIND_US_STOP      = 3'd4,
    KIND_READ_SLOTS   = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCKS_PER_MS = 1'b0,
    REG_US_SCALE      = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STOP_RD,
    ST_DT,
    ST_MS_WAIT,
    ST_STOP_OUT,
    ST_DIV_A_GO,
    ST_DIV_A_WAIT,
    ST_DIV_B_GO,
    ST_DIV_B_WAIT,
    ST_US_MUL,
    ST_US_OUT,
    ST_RD_ISSUE,
    ST_RD_EMIT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [DELTA_W-1:0]        elapsed_ms;
    logic [DELTA_W-1:0]        window_max_ms;
    logic [DELTA_W-1:0]        max_raw_delta;
    logic [US_W-1:0]           microseconds;
    logic signed [DELTA_W-1:0] slot_delta;
    logic [SLOT_NUM_W-1:0]     slot_number;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic start;
    logic half;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/etr_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle, 64 or 32 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_div (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  etr_pkg::div_req_t                    req_i,
  input  wire  [etr_pkg::STAMP_W-1:0]          dividend_i,
  input  wire  [etr_pkg::DELTA_W-1:0]          divisor_i,
  output etr_pkg::div_rsp_t                    rsp_o,
  output logic [etr_pkg::STAMP_W-1:0]          quotient_o
);

  logic [etr_pkg::STAMP_W-1:0]   acc_q, acc_d;
  logic [etr_pkg::DELTA_W-1:0]   rem_q, rem_d;
  logic [etr_pkg::DELTA_W-1:0]   den_q, den_d;
  logic [etr_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [etr_pkg::DELTA_W:0]     trial;
  logic                          fits;

  assign trial = {rem_q, acc_q[etr_pkg::STAMP_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      // A half-width dividend sits in the upper word, the quotient lands low
      acc_d  = req_i.half ? {dividend_i[etr_pkg::DELTA_W-1:0], {etr_pkg::DELTA_W{1'b0}}}
                          : dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = req_i.half ? etr_pkg::DIV_CNT_W'(etr_pkg::DIV_STEPS_HALF)
                          : etr_pkg::DIV_CNT_W'(etr_pkg::DIV_STEPS_FULL);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? etr_pkg::DELTA_W'(trial - {1'b0, den_q})
                   : trial[etr_pkg::DELTA_W-1:0];
      acc_d = {acc_q[etr_pkg::STAMP_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == etr_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/etr_mem.sv -----
// ----------------------------------------------------------------------------
// Stamp memory
// One write port, one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module etr_mem #(
  parameter int unsigned DEPTH = etr_pkg::SLOT_COUNT_DEF,
  parameter int unsigned WIDTH = etr_pkg::STAMP_W,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              we_i,
  input  wire  [AW-1:0]    waddr_i,
  input  wire  [WIDTH-1:0] wdata_i,
  input  wire  [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/elapsed_time_recorder.sv -----
// ----------------------------------------------------------------------------
// Elapsed time recorder
// Timestamped event recorder with slot ring, running maxima and us timer.
// ----------------------------------------------------------------------------
// Input words carry an event kind and a 64-bit timestamp; output words carry
// the slot-stop, microsecond or slot-readout results. Both channels use
// valid/stall. The config port writes clocks_per_ms (index 0) and
// us_scale_q24 (index 1) with no wait; write only while the block is idle.
// One word is worked on at a time and the input stalls until it finishes:
//   slot start, us start: no output word.
//   slot stop: one pass of the 32-step serial divider.
//   slot stop in ms mode: as slot stop; the same divider then runs two
//     64-step passes to scale the stored stamps.
//   us stop: one 32x32 multiply, then one round and saturate.
//   read slots: one output word per slot, each read through the single
//     registered read port of the stamp memories.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and a word that produces output holds until that register is
// free. Receiver stall therefore only delays, never drops. Reset clears all
// counters, maxima, stamps and config registers to their reset values at
// once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module elapsed_time_recorder #(
  parameter int unsigned SLOT_COUNT   = etr_pkg::SLOT_COUNT_DEF,
  parameter int unsigned WINDOW_CALLS = etr_pkg::WINDOW_CALLS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  etr_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output etr_pkg::out_t                   out_data_o,
  input  wire                             cfg_we_i,
  input  wire  [etr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [etr_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned CW = $clog2(WINDOW_CALLS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] CALL_LAST = CW'(WINDOW_CALLS - 1);

  etr_pkg::state_e state_q, state_d;

  logic [etr_pkg::CFG_W-1:0]   cpm_q, cpm_d;
  logic [etr_pkg::CFG_W-1:0]   scale_q, scale_d;
  logic [CW-1:0]               cc_q, cc_d;
  logic [SW-1:0]               slot_q, slot_d;
  logic [SW-1:0]               idx_q, idx_d;
  logic [etr_pkg::DELTA_W-1:0] wmax_q, wmax_d;
  logic [etr_pkg::DELTA_W-1:0] rmax_q, rmax_d;
  logic [etr_pkg::STAMP_W-1:0] us_start_q, us_start_d;
  logic                        out_valid_q, out_valid_d;
  etr_pkg::out_t               out_q, out_d;

  logic [etr_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic [etr_pkg::STAMP_W-1:0] ts_q, ts_d;
  logic [etr_pkg::STAMP_W-1:0] start_q, start_d;
  logic [etr_pkg::DELTA_W-1:0] dt_q, dt_d;
  logic [etr_pkg::DELTA_W-1:0] ms_q, ms_d;
  logic [etr_pkg::DELTA_W-1:0] us_delta_q, us_delta_d;
  logic [etr_pkg::PROD_W-1:0]  prod_q, prod_d;

  logic                        start_we, stop_we;
  logic [SW-1:0]               start_waddr, stop_waddr;
  logic [etr_pkg::STAMP_W-1:0] start_wdata, stop_wdata;
  logic [etr_pkg::STAMP_W-1:0] start_rdata, stop_rdata;

  etr_pkg::div_req_t           div_req;
  etr_pkg::div_rsp_t           div_rsp;
  logic [etr_pkg::STAMP_W-1:0] div_dividend;
  logic [etr_pkg::DELTA_W-1:0] div_divisor;
  logic [etr_pkg::STAMP_W-1:0] div_quot;

  logic                        out_free;
  logic [etr_pkg::DELTA_W-1:0] dt_now;
  logic [etr_pkg::DELTA_W-1:0] ms_now;
  logic [etr_pkg::PROD_W:0]    rounded;
  logic [etr_pkg::PROD_W-etr_pkg::US_FRAC_W:0] us_full;
  logic [SW+etr_pkg::SLOT_NUM_W-1:0] idx_ext;
  logic [CW-1:0]               cc_next;
  logic [SW-1:0]               slot_next;

  etr_mem #(.DEPTH(SLOT_COUNT), .WIDTH(etr_pkg::STAMP_W)) u_start_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (start_we),
    .waddr_i (start_waddr),
    .wdata_i (start_wdata),
    .raddr_i (idx_q),
    .rdata_o (start_rdata)
  );

  etr_mem #(.DEPTH(SLOT_COUNT), .WIDTH(etr_pkg::STAMP_W)) u_stop_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (stop_we),
    .waddr_i (stop_waddr),
    .wdata_i (stop_wdata),
    .raddr_i (idx_q),
    .rdata_o (stop_rdata)
  );

  etr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rsp_o      (div_rsp),
    .quotient_o (div_quot)
  );

  assign div_divisor = (cpm_q == '0) ? etr_pkg::DELTA_W'(1) : cpm_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign dt_now      = ts_q[etr_pkg::DELTA_W-1:0] - start_rdata[etr_pkg::DELTA_W-1:0];
  assign ms_now      = div_quot[etr_pkg::DELTA_W-1:0];
  assign rounded     = {1'b0, prod_q} +
                       ((etr_pkg::PROD_W+1)'(1) << (etr_pkg::US_FRAC_W - 1));
  assign us_full     = rounded[etr_pkg::PROD_W:etr_pkg::US_FRAC_W];
  assign idx_ext     = {{etr_pkg::SLOT_NUM_W{1'b0}}, idx_q};
  assign cc_next     = (cc_q == CALL_LAST) ? '0 : cc_q + 1'b1;
  // Slot follows count mod SLOT_COUNT; it restarts with the count's wrap
  assign slot_next   = (cc_q == CALL_LAST || slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    cpm_d       = cpm_q;
    scale_d     = scale_q;
    cc_d        = cc_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    wmax_d      = wmax_q;
    rmax_d      = rmax_q;
    us_start_d  = us_start_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    kind_d      = kind_q;
    ts_d        = ts_q;
    start_d     = start_q;
    dt_d        = dt_q;
    ms_d        = ms_q;
    us_delta_d  = us_delta_q;
    prod_d      = prod_q;
    in_stall_o  = 1'b1;
    start_we    = 1'b0;
    stop_we     = 1'b0;
    start_waddr = idx_q;
    stop_waddr  = idx_q;
    start_wdata = div_quot;
    stop_wdata  = div_quot;
    div_req     = '0;
    div_dividend = ts_q;

    if (cfg_we_i) begin
      unique case (etr_pkg::cfg_reg_e'(cfg_idx_i))
        etr_pkg::REG_CLOCKS_PER_MS: cpm_d   = cfg_data_i;
        etr_pkg::REG_US_SCALE:      scale_d = cfg_data_i;
      endcase
    end

    unique case (state_q)
      etr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          kind_d = in_data_i.kind;
          ts_d   = in_data_i.timestamp;
          case (in_data_i.kind)
            etr_pkg::KIND_SLOT_START: begin
              cc_d        = cc_next;
              slot_d      = slot_next;
              start_we    = 1'b1;
              start_waddr = slot_next;
              start_wdata = in_data_i.timestamp;
            end
            etr_pkg::KIND_SLOT_STOP, etr_pkg::KIND_SLOT_STOP_MS: begin
              stop_we    = 1'b1;
              stop_waddr = slot_q;
              stop_wdata = in_data_i.timestamp;
              idx_d      = slot_q;
              state_d    = etr_pkg::ST_STOP_RD;
            end
            etr_pkg::KIND_US_START: begin
              us_start_d = in_data_i.timestamp;
            end
            etr_pkg::KIND_US_STOP: begin
              us_delta_d = in_data_i.timestamp[etr_pkg::DELTA_W-1:0]
                         - us_start_q[etr_pkg::DELTA_W-1:0];
              state_d    = etr_pkg::ST_US_MUL;
            end
            etr_pkg::KIND_READ_SLOTS: begin
              idx_d   = '0;
              state_d = etr_pkg::ST_RD_ISSUE;
            end
            default: ;
          endcase
        end
      end
      etr_pkg::ST_STOP_RD: state_d = etr_pkg::ST_DT;
      etr_pkg::ST_DT: begin
        dt_d          = dt_now;
        start_d       = start_rdata;
        div_req.start = 1'b1;
        div_req.half  = 1'b1;
        div_dividend  = {{etr_pkg::DELTA_W{1'b0}}, dt_now};
        state_d       = etr_pkg::ST_MS_WAIT;
      end
      etr_pkg::ST_MS_WAIT: begin
        if (div_rsp.done) begin
          ms_d = ms_now;
          // Window boundary: drop both maxima, then take this stop's ms
          if (cc_q == '0) begin
            rmax_d = '0;
            wmax_d = ms_now;
          end else begin
            rmax_d = (rmax_q < dt_q) ? dt_q : rmax_q;
            wmax_d = (wmax_q < ms_now) ? ms_now : wmax_q;
          end
          state_d = etr_pkg::ST_STOP_OUT;
        end
      end
      etr_pkg::ST_STOP_OUT: begin
        if (out_free) begin
          out_d               = '0;
          out_d.elapsed_ms    = ms_q;
          out_d.window_max_ms = wmax_q;
          out_d.max_raw_delta = rmax_q;
          out_d.slot_number   = idx_ext[etr_pkg::SLOT_NUM_W-1:0];
          out_d.last          = 1'b1;
          out_valid_d         = 1'b1;
          state_d = (kind_q == etr_pkg::KIND_SLOT_STOP_MS) ? etr_pkg::ST_DIV_A_GO
                                                          : etr_pkg::ST_IDLE;
        end
      end
      etr_pkg::ST_DIV_A_GO: begin
        div_req.start = 1'b1;
        div_dividend  = ts_q;
        state_d       = etr_pkg::ST_DIV_A_WAIT;
      end
      etr_pkg::ST_DIV_A_WAIT: begin
        if (div_rsp.done) begin
          stop_we = 1'b1;
          state_d = etr_pkg::ST_DIV_B_GO;
        end
      end
      etr_pkg::ST_DIV_B_GO: begin
        div_req.start = 1'b1;
        div_dividend  = start_q;
        state_d       = etr_pkg::ST_DIV_B_WAIT;
      end
      etr_pkg::ST_DIV_B_WAIT: begin
        if (div_rsp.done) begin
          start_we = 1'b1;
          state_d  = etr_pkg::ST_IDLE;
        end
      end
      etr_pkg::ST_US_MUL: begin
        prod_d  = us_delta_q * scale_q;
        state_d = etr_pkg::ST_US_OUT;
      end
      etr_pkg::ST_US_OUT: begin
        if (out_free) begin
          out_d              = '0;
          // Saturate to the 31-bit field
          out_d.microseconds = (|us_full[etr_pkg::PROD_W-etr_pkg::US_FRAC_W:etr_pkg::US_W])
                             ? '1 : us_full[etr_pkg::US_W-1:0];
          out_d.last         = 1'b1;
          out_valid_d        = 1'b1;
          state_d            = etr_pkg::ST_IDLE;
        end
      end
      etr_pkg::ST_RD_ISSUE: state_d = etr_pkg::ST_RD_EMIT;
      etr_pkg::ST_RD_EMIT: begin
        // Hold the read address until the word leaves
        if (out_free) begin
          out_d             = '0;
          out_d.slot_delta  = signed'(stop_rdata[etr_pkg::DELTA_W-1:0]
                                      - start_rdata[etr_pkg::DELTA_W-1:0]);
          out_d.slot_number = idx_ext[etr_pkg::SLOT_NUM_W-1:0];
          out_d.last        = (idx_q == SLOT_LAST);
          out_valid_d       = 1'b1;
          if (idx_q == SLOT_LAST) begin
            state_d = etr_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = etr_pkg::ST_RD_ISSUE;
          end
        end
      end
      default: state_d = etr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpm_q       <= etr_pkg::CLOCKS_PER_MS_RST;
      scale_q     <= etr_pkg::US_SCALE_RST;
      cc_q        <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      wmax_q      <= '0;
      rmax_q      <= '0;
      us_start_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cpm_q       <= cpm_d;
      scale_q     <= scale_d;
      cc_q        <= cc_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      wmax_q      <= wmax_d;
      rmax_q      <= rmax_d;
      us_start_q  <= us_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    kind_q     <= kind_d;
    ts_q       <= ts_d;
    start_q    <= start_d;
    dt_q       <= dt_d;
    ms_q       <= ms_d;
    us_delta_q <= us_delta_d;
    prod_q     <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == etr_pkg::ST_MS_WAIT || state_q == etr_pkg::ST_DIV_A_WAIT ||
                      state_q == etr_pkg::ST_DIV_B_WAIT))
    else $error("divider finished outside a wait state");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_read_begins_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etr_pkg::ST_IDLE && in_valid_i &&
     in_data_i.kind == etr_pkg::KIND_READ_SLOTS)
    |=> (state_q == etr_pkg::ST_RD_ISSUE && idx_q == '0))
    else $error("slot readout did not start at slot zero");

  a_read_ends_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etr_pkg::ST_RD_EMIT && out_free && idx_q == SLOT_LAST)
    |=> (state_q == etr_pkg::ST_IDLE && out_valid_o && out_data_o.last))
    else $error("slot readout ended without a last word");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_q <= SLOT_LAST && cc_q <= CALL_LAST))
    else $error("slot or call count out of range");

endmodule

`default_nettype wire
